>>> rtl/core/hdlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_pkg
// Shared types, constants and helper functions of the bit-stuffing framer.
// ----------------------------------------------------------------------------
package hdlc_pkg;

	localparam int unsigned FRAME_PAYLOAD_BITS = 100;
	localparam int unsigned POS_W = 7;

	localparam logic [7:0]  FLAG_OCTET   = 8'h7E;
	localparam logic [15:0] CCITT_GEN    = 16'h1021;

	localparam logic [7:0]  SENDER_RESET   = 8'h01;
	localparam logic [7:0]  RECEIVER_RESET = 8'h02;
	localparam logic [7:0]  CONTROL_RESET  = 8'hCC;
	localparam logic [15:0] CRC_START_RESET = 16'hFFFF;

	localparam logic [4:0] OCTET_BITS = 5'd8;
	localparam logic [4:0] WORD_BITS  = 5'd16;
	localparam logic [4:0] ONE_BIT    = 5'd1;
	localparam logic [2:0] STUFF_RUN  = 3'd5;

	typedef enum logic [1:0] {
		REG_SENDER   = 2'd0,
		REG_RECEIVER = 2'd1,
		REG_CONTROL  = 2'd2,
		REG_CRC_INIT = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic mode;
		logic payload_bit;
	} in_item_t;

	typedef struct packed {
		logic line_bit;
		logic stuffed_zero;
		logic frame_end;
		logic finish_error;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic step;
		logic restart;
		logic data_bit;
	} crc_ctrl_t;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic data_bit);
		logic [15:0] r;
		r = {crc[14:0], 1'b0};
		if (crc[15] ^ data_bit) begin
			r = r ^ CCITT_GEN;
		end
		return r;
	endfunction

	// Eight-bit sum with the carry folded back into the low end.
	function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

endpackage

>>> rtl/core/hdlc_bit_stuffing_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_bit_stuffing_framer
// Bit-serial HDLC-style framer with CRC-16, bit stuffing and a closing
// checksum frame.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one word per payload bit (mode 0) or a finish word
// (mode 1). Each word produces a run of line bits on the output channel, one
// bit per cycle while the receiver is ready, with last set on the final bit
// of the run. A new input word is taken only once the previous run has been
// fully issued; the output register lets the next word be accepted while
// the last bit still waits. The first line bit passes through the state
// register and then the output register. A payload bit in the middle of a
// frame gives one line bit, followed by a stuffed zero when one is due. The
// first bit of a frame adds 40 header bits, the last adds 24 CRC and flag
// bits, and a finish produces 48 bits, each plus any stuffed zeros. A
// mid-frame finish gives a single error word.
// Reset clears the frame position, sequence number, CRC sum and loads the
// registers with their defaults. When the receiver stalls, the output word
// is held and the sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module hdlc_bit_stuffing_framer
	import hdlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  cfg_index_t  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_OPEN     = 11'b000_0000_0010,
		ST_SENDER   = 11'b000_0000_0100,
		ST_RECEIVER = 11'b000_0000_1000,
		ST_SEQ      = 11'b000_0001_0000,
		ST_PAYLOAD  = 11'b000_0010_0000,
		ST_CRC      = 11'b000_0100_0000,
		ST_CONTROL  = 11'b000_1000_0000,
		ST_SUM      = 11'b001_0000_0000,
		ST_CLOSE    = 11'b010_0000_0000,
		ST_ERROR    = 11'b100_0000_0000
	} state_t;

	logic [7:0]  sender_q, receiver_q, control_q;
	logic [15:0] crc_init_q;

	state_t           state_q, state_d, nxt_state;
	logic [15:0]      sh_q, sh_d, nxt_sh;
	logic [4:0]       cnt_q, cnt_d, nxt_cnt;
	logic             stuff_q, stuff_d;
	logic [2:0]       ones_q, ones_d, ones_nxt;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      seq_q;
	logic [7:0]       sum_q;
	logic             fin_q, frame_done_q, bit_q;
	logic             out_valid_q;
	out_item_t        out_q, out_d;

	logic        in_fire, emit, adv, stuffed_state;
	logic [7:0]  pos_inc;
	logic [15:0] crc;
	crc_ctrl_t   crc_ctrl;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign emit      = (state_q != ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pos_inc   = {1'b0, pos_q} + 8'd1;

	assign crc_ctrl.step     = in_fire && !in_data.mode;
	assign crc_ctrl.restart  = (pos_q == '0);
	assign crc_ctrl.data_bit = in_data.payload_bit;

	hdlc_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.start  (crc_init_q),
		.crc    (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_q   <= SENDER_RESET;
			receiver_q <= RECEIVER_RESET;
			control_q  <= CONTROL_RESET;
			crc_init_q <= CRC_START_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENDER:   sender_q   <= cfg_data[7:0];
				REG_RECEIVER: receiver_q <= cfg_data[7:0];
				REG_CONTROL:  control_q  <= cfg_data[7:0];
				REG_CRC_INIT: crc_init_q <= cfg_data;
			endcase
		end
	end

	// Field that follows the current one, left-aligned in the shift register.
	always_comb begin
		nxt_state = ST_IDLE;
		nxt_sh    = '0;
		nxt_cnt   = '0;
		unique case (state_q)
			ST_OPEN: begin
				nxt_state = ST_SENDER;
				nxt_sh    = {sender_q, 8'd0};
				nxt_cnt   = OCTET_BITS;
			end
			ST_SENDER: begin
				nxt_state = ST_RECEIVER;
				nxt_sh    = {receiver_q, 8'd0};
				nxt_cnt   = OCTET_BITS;
			end
			ST_RECEIVER: begin
				if (fin_q) begin
					nxt_state = ST_CONTROL;
					nxt_sh    = {control_q, 8'd0};
					nxt_cnt   = OCTET_BITS;
				end else begin
					nxt_state = ST_SEQ;
					nxt_sh    = seq_q;
					nxt_cnt   = WORD_BITS;
				end
			end
			ST_SEQ: begin
				nxt_state = ST_PAYLOAD;
				nxt_sh    = {bit_q, 15'd0};
				nxt_cnt   = ONE_BIT;
			end
			ST_PAYLOAD: begin
				if (frame_done_q) begin
					nxt_state = ST_CRC;
					nxt_sh    = crc;
					nxt_cnt   = WORD_BITS;
				end
			end
			ST_CONTROL: begin
				nxt_state = ST_SUM;
				nxt_sh    = {~sum_q, 8'd0};
				nxt_cnt   = OCTET_BITS;
			end
			ST_CRC, ST_SUM: begin
				nxt_state = ST_CLOSE;
				nxt_sh    = {FLAG_OCTET, 8'd0};
				nxt_cnt   = OCTET_BITS;
			end
			ST_IDLE, ST_CLOSE, ST_ERROR: begin
				nxt_state = ST_IDLE;
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	assign stuffed_state = (state_q != ST_IDLE) && (state_q != ST_OPEN)
		&& (state_q != ST_CLOSE) && (state_q != ST_ERROR);
	assign ones_nxt = sh_q[15] ? (ones_q + 3'd1) : 3'd0;

	always_comb begin
		state_d = state_q;
		sh_d    = sh_q;
		cnt_d   = cnt_q;
		stuff_d = stuff_q;
		ones_d  = ones_q;
		out_d   = out_q;
		adv     = 1'b0;
		if (in_fire) begin
			if (in_data.mode && (pos_q != '0)) begin
				state_d = ST_ERROR;
			end else if (in_data.mode || (pos_q == '0)) begin
				state_d = ST_OPEN;
				sh_d    = {FLAG_OCTET, 8'd0};
				cnt_d   = OCTET_BITS;
				ones_d  = '0;
			end else begin
				state_d = ST_PAYLOAD;
				sh_d    = {in_data.payload_bit, 15'd0};
				cnt_d   = ONE_BIT;
			end
		end
		if (emit) begin
			out_d = '0;
			if (state_q == ST_ERROR) begin
				out_d.finish_error = 1'b1;
				adv = 1'b1;
			end else if (stuff_q) begin
				out_d.stuffed_zero = 1'b1;
				stuff_d = 1'b0;
				adv = (cnt_q == '0);
			end else begin
				out_d.line_bit = sh_q[15];
				out_d.frame_end = (state_q == ST_CLOSE) && (cnt_q == ONE_BIT);
				sh_d  = {sh_q[14:0], 1'b0};
				cnt_d = cnt_q - 5'd1;
				adv   = (cnt_q == ONE_BIT);
				if (stuffed_state) begin
					if (ones_nxt == STUFF_RUN) begin
						stuff_d = 1'b1;
						ones_d  = '0;
						adv     = 1'b0;
					end else begin
						ones_d = ones_nxt;
					end
				end
			end
			if (adv) begin
				state_d    = nxt_state;
				sh_d       = nxt_sh;
				cnt_d      = nxt_cnt;
				out_d.last = (nxt_state == ST_IDLE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			stuff_q      <= 1'b0;
			ones_q       <= '0;
			pos_q        <= '0;
			seq_q        <= '0;
			sum_q        <= '0;
			fin_q        <= 1'b0;
			frame_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			stuff_q <= stuff_d;
			ones_q  <= ones_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				fin_q <= in_data.mode;
				if (!in_data.mode) begin
					frame_done_q <= (pos_inc >= 8'(FRAME_PAYLOAD_BITS));
					if (pos_inc >= 8'(FRAME_PAYLOAD_BITS)) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_inc[POS_W-1:0];
					end
				end
			end
			if (emit && adv && (nxt_state == ST_CRC)) begin
				sum_q <= eac_add(eac_add(sum_q, crc[15:8]), crc[7:0]);
				seq_q <= seq_q + 16'd1;
			end
			// The checksum frame closes the session: back to the reset state.
			if (emit && adv && (state_q == ST_CLOSE) && fin_q) begin
				sum_q <= '0;
				seq_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sh_q <= sh_d;
		out_q <= out_d;
		if (in_fire) begin
			bit_q <= in_data.payload_bit;
		end
	end

endmodule

>>> rtl/core/hdlc_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_crc16
// Bit-serial CRC-16 register, one payload bit per step, reloadable from the
// configured start value at the first bit of each frame.
// ----------------------------------------------------------------------------
module hdlc_crc16
	import hdlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  crc_ctrl_t   ctrl,
	input  logic [15:0] start,
	output logic [15:0] crc
);

	logic [15:0] crc_q;
	logic [15:0] base;

	assign base = ctrl.restart ? start : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_START_RESET;
		end else if (ctrl.step) begin
			crc_q <= crc16_step(base, ctrl.data_bit);
		end
	end

	assign crc = crc_q;

endmodule

>>> rtl/core/hdlc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_checker
// Port-level checks of the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hdlc_checker
	import hdlc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A closing flag always ends the run of its input word.
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.last)
		else $error("closing flag bit without last");

	a_stuff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stuffed_zero |-> !out_data.line_bit && !out_data.frame_end)
		else $error("stuffed bit is not a plain zero");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.finish_error |-> out_data.last && !out_data.line_bit)
		else $error("error word is not a lone zero word");

	// One input word at a time: no intake straight after an accepted word.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

endmodule

bind hdlc_bit_stuffing_framer hdlc_checker u_hdlc_checker (.*);
